/* rtl/core/mqlb_pkg.sv */
// mqlb_pkg: shared sizes, kind codes and status codes for the linked block queue buffer
// no dependencies
`default_nettype none
package mqlb_pkg;
    // pool and queue sizes, fixed by the port widths
    localparam int MAX_QUEUES      = 1024;
    localparam int NUM_BLOCKS      = 4096;
    localparam int SLOTS_PER_BLOCK = 7;
    localparam int HANDLE_BITS     = 32;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CREATE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] ST_APPENDED   = 3'd0;
    localparam logic [2:0] ST_REMOVED    = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_BAD_QUEUE  = 3'd3;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd4;
    localparam logic [2:0] ST_NO_BLOCKS  = 3'd5;
    localparam logic [2:0] ST_CORRUPT    = 3'd6;
    localparam logic [2:0] ST_CREATED    = 3'd7;
endpackage
`default_nettype wire

/* rtl/core/multi_queue_linked_block_buffer_unit.sv */
// multi_queue_linked_block_buffer_unit: queues of handles in a shared pool of linked blocks
// depends on mqlb_pkg
//
// channel | ports                                        | dir
// s_      | s_valid s_ready s_kind s_queue_id s_packet_in| in
// m_      | m_valid m_ready m_status m_packet_out ...    | out
// cfg_    | cfg_valid cfg_ready cfg_data                 | in
//
// one word at a time: create and rejected words finish in idle, a remove passes head
// and block, an append that starts a queue passes head and free, an append into the
// tail block passes head, block and tail, and one that links a new block behind the
// tail also free and done; the states follow the dependent reads of heads, links, slots.
// after reset a clearing pass walks every block, rebuilding
// the free chain and zeroing links and slots; no word is taken during it.
// the result sits in an output register; the next word is taken in the cycle it leaves.
`default_nettype none
module multi_queue_linked_block_buffer_unit
    import mqlb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [10:0] s_queue_id,
    input  wire logic [31:0] s_packet_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_packet_out,
    output logic [10:0]      m_new_queue_id,
    output logic [12:0]      m_free_blocks,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);
    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int QW = $clog2(MAX_QUEUES);
    localparam int SW = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
    localparam int SLW = SLOTS_PER_BLOCK * HANDLE_BITS;
    localparam logic [BW-1:0] LAST_BLK = BW'(NUM_BLOCKS - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HEAD  = 7'b0000100,
        S_BLK   = 7'b0001000,
        S_TAIL  = 7'b0010000,
        S_FREE  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    // memories: queue heads, block next links, tail links, slot rows
    logic [BW-1:0]  head_mem [MAX_QUEUES];
    logic [BW-1:0]  next_mem [NUM_BLOCKS];
    logic [BW-1:0]  tail_mem [NUM_BLOCKS];
    logic [SLW-1:0] slot_mem [NUM_BLOCKS];

    state_t         state_reg, state_next;
    logic [BW-1:0]  clr_reg;
    logic [10:0]    qiu_reg;
    logic [BW-1:0]  free_head_reg;
    logic [12:0]    free_count_reg;
    logic [16:0]    nnq_reg;
    logic [1:0]     kind_reg;
    logic [QW-1:0]  qidx_reg;
    logic [HANDLE_BITS-1:0] pkt_reg;
    logic [BW-1:0]  head_reg, tail_reg;
    logic [BW-1:0]  newblk_reg;
    logic           m_valid_reg;
    logic [2:0]     st_reg;
    logic [31:0]    pout_reg;
    logic [10:0]    newq_reg;

    // read ports and registered data
    logic [QW-1:0]  hq_raddr;
    logic [BW-1:0]  b_raddr;
    logic [BW-1:0]  head_rd, next_rd, tail_rd;
    logic [SLW-1:0] slot_rd;

    // write requests
    logic           hw_en, nw_en, tw_en, sw_en;
    logic [QW-1:0]  hw_addr;
    logic [BW-1:0]  hw_data, nw_addr, nw_data, tw_addr, tw_data, sw_addr;
    logic [SLW-1:0] sw_data;

    always_ff @(posedge aclk) begin
        head_rd <= head_mem[hq_raddr];
        next_rd <= next_mem[b_raddr];
        tail_rd <= tail_mem[b_raddr];
        slot_rd <= slot_mem[b_raddr];
        if (hw_en) head_mem[hw_addr] <= hw_data;
        if (nw_en) next_mem[nw_addr] <= nw_data;
        if (tw_en) tail_mem[tw_addr] <= tw_data;
        if (sw_en) slot_mem[sw_addr] <= sw_data;
    end

    // read row padded with one empty slot past the end
    logic [SLW+HANDLE_BITS-1:0] row_pad;
    assign row_pad = {{HANDLE_BITS{1'b0}}, slot_rd};

    // slot search on the read row
    logic           has_empty, has_valid, last_in_row;
    logic [SW-1:0]  empty_idx, valid_idx;
    logic [HANDLE_BITS-1:0] valid_val;
    always_comb begin
        has_empty = 1'b0; has_valid = 1'b0; last_in_row = 1'b0;
        empty_idx = '0; valid_idx = '0; valid_val = '0;
        for (int i = SLOTS_PER_BLOCK - 1; i >= 0; i--) begin
            if (slot_rd[i*HANDLE_BITS +: HANDLE_BITS] == '0) begin
                has_empty = 1'b1; empty_idx = SW'(i);
            end
        end
        for (int i = SLOTS_PER_BLOCK - 1; i >= 0; i--) begin
            if (slot_rd[i*HANDLE_BITS +: HANDLE_BITS] != '0) begin
                has_valid = 1'b1; valid_idx = SW'(i);
                valid_val = slot_rd[i*HANDLE_BITS +: HANDLE_BITS];
                last_in_row = (row_pad[(i+1)*HANDLE_BITS +: HANDLE_BITS] == '0);
            end
        end
    end

    logic q_ok, can_alloc, fire_in;
    assign q_ok = (s_queue_id != 11'd0) && (s_queue_id <= qiu_reg) &&
                  ({6'd0, s_queue_id} <= 17'(MAX_QUEUES));
    assign can_alloc = (free_count_reg > 13'd1) && (free_head_reg != '0);
    assign s_ready   = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;
    assign fire_in   = s_valid && s_ready;

    logic [BW-1:0] fh_next;
    logic [12:0]   fc_next;
    logic [16:0]   nnq_next;
    logic          res_load;
    logic [2:0]    res_st;
    logic [31:0]   res_pout;
    logic [10:0]   res_newq;
    logic [BW-1:0] head_next, tail_next;
    logic [SLW-1:0] row_w;

    // control sequencer
    always_comb begin
        state_next = state_reg;
        hq_raddr = qidx_reg; b_raddr = head_reg;
        hw_en = 1'b0; nw_en = 1'b0; tw_en = 1'b0; sw_en = 1'b0;
        hw_addr = qidx_reg; hw_data = '0;
        nw_addr = '0; nw_data = '0; tw_addr = '0; tw_data = '0;
        sw_addr = '0; sw_data = '0;
        fh_next = free_head_reg; fc_next = free_count_reg; nnq_next = nnq_reg;
        res_load = 1'b0; res_st = ST_BAD_QUEUE; res_pout = '0; res_newq = '0;
        head_next = head_reg; tail_next = tail_reg;
        row_w = slot_rd;
        case (state_reg)
            S_CLEAR: begin
                hw_en = (clr_reg < BW'(MAX_QUEUES)) || (BW < QW);
                hw_addr = QW'(clr_reg);
                nw_en = 1'b1; nw_addr = clr_reg;
                nw_data = (clr_reg == LAST_BLK) ? '0 : clr_reg + 1'b1;
                tw_en = 1'b1; tw_addr = clr_reg;
                sw_en = 1'b1; sw_addr = clr_reg;
                if (clr_reg == LAST_BLK) state_next = S_IDLE;
            end
            S_IDLE: begin
                hq_raddr = QW'(s_queue_id - 11'd1);
                if (fire_in) begin
                    if (s_kind == KIND_CREATE) begin
                        if (nnq_reg <= 17'(MAX_QUEUES)) nnq_next = nnq_reg + 17'd1;
                        if (nnq_reg <= {6'd0, qiu_reg} && nnq_reg <= 17'(MAX_QUEUES))
                            res_newq = 11'(nnq_reg);
                        res_st = ST_CREATED; res_load = 1'b1;
                    end else if (s_kind == KIND_UNUSED || !q_ok) begin
                        res_st = ST_BAD_QUEUE; res_load = 1'b1;
                    end else if (s_kind == KIND_APPEND && s_packet_in == '0) begin
                        res_st = ST_BAD_HANDLE; res_load = 1'b1;
                    end else begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                head_next = head_rd;
                b_raddr = head_rd;
                if (head_rd == '0) begin
                    if (kind_reg == KIND_REMOVE) begin
                        res_st = ST_EMPTY; res_load = 1'b1; state_next = S_IDLE;
                    end else if (!can_alloc) begin
                        res_st = ST_NO_BLOCKS; res_load = 1'b1; state_next = S_IDLE;
                    end else begin
                        state_next = S_FREE; b_raddr = free_head_reg;
                    end
                end else begin
                    state_next = S_BLK;
                end
            end
            S_BLK: begin
                if (kind_reg == KIND_REMOVE) begin
                    if (!has_valid) begin
                        res_st = ST_CORRUPT; res_load = 1'b1; state_next = S_IDLE;
                    end else begin
                        row_w[valid_idx*HANDLE_BITS +: HANDLE_BITS] = '0;
                        sw_en = 1'b1; sw_addr = head_reg; sw_data = row_w;
                        res_st = ST_REMOVED; res_pout = 32'(valid_val);
                        res_load = 1'b1; state_next = S_IDLE;
                        if (last_in_row) begin
                            hw_en = 1'b1; hw_data = next_rd;
                            if (next_rd != '0) begin
                                tw_en = 1'b1; tw_addr = next_rd; tw_data = tail_rd;
                            end
                            nw_en = 1'b1; nw_addr = head_reg; nw_data = free_head_reg;
                            fh_next = head_reg; fc_next = free_count_reg + 13'd1;
                        end
                    end
                end else begin
                    // append: find the tail block
                    tail_next = (tail_rd == '0) ? head_reg : tail_rd;
                    b_raddr = tail_next;
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                b_raddr = free_head_reg;
                if (has_empty) begin
                    row_w[empty_idx*HANDLE_BITS +: HANDLE_BITS] = pkt_reg;
                    sw_en = 1'b1; sw_addr = tail_reg; sw_data = row_w;
                    res_st = ST_APPENDED; res_load = 1'b1; state_next = S_IDLE;
                end else if (!can_alloc) begin
                    res_st = ST_NO_BLOCKS; res_load = 1'b1; state_next = S_IDLE;
                end else begin
                    state_next = S_FREE;
                end
            end
            S_FREE: begin
                // next_rd holds the free head's link; allocate it
                fh_next = next_rd; fc_next = free_count_reg - 13'd1;
                nw_en = 1'b1; nw_addr = free_head_reg; nw_data = '0;
                tw_en = 1'b1; tw_addr = free_head_reg; tw_data = '0;
                sw_en = 1'b1; sw_addr = free_head_reg;
                sw_data = SLW'(pkt_reg);
                if (head_reg == '0) begin
                    hw_en = 1'b1; hw_data = free_head_reg;
                    res_st = ST_APPENDED; res_load = 1'b1; state_next = S_IDLE;
                end else begin
                    tw_addr = head_reg; tw_data = free_head_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // link the old tail to the new block
                nw_en = 1'b1; nw_addr = tail_reg; nw_data = newblk_reg;
                res_st = ST_APPENDED; res_load = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR; clr_reg <= '0; qiu_reg <= 11'd1024;
            free_head_reg <= BW'(1); free_count_reg <= 13'(NUM_BLOCKS - 1);
            nnq_reg <= 17'd1; m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cfg_valid) qiu_reg <= cfg_data;
            free_head_reg <= fh_next; free_count_reg <= fc_next; nnq_reg <= nnq_next;
            if (res_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // word capture, block pointers and result register
    always_ff @(posedge aclk) begin
        if (fire_in) begin
            kind_reg <= s_kind; qidx_reg <= QW'(s_queue_id - 11'd1);
            pkt_reg <= HANDLE_BITS'(s_packet_in);
        end
        head_reg <= head_next; tail_reg <= tail_next;
        if (state_reg == S_FREE) newblk_reg <= free_head_reg;
        if (res_load) begin
            st_reg <= res_st; pout_reg <= res_pout; newq_reg <= res_newq;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_status = st_reg;
    assign m_packet_out = pout_reg;
    assign m_new_queue_id = newq_reg;
    assign m_free_blocks = free_count_reg;

    // checks
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("accept while busy");
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= 13'(NUM_BLOCKS - 1)) else $error("free count overflow");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
endmodule
`default_nettype wire

/* bench/multi_queue_linked_block_buffer_unit_test.sv */
// multi_queue_linked_block_buffer_unit_test: checks the linked block queue buffer
// with a directed table followed by random append, remove and create traffic
// depends on mqlb_pkg and multi_queue_linked_block_buffer_unit
`default_nettype none
module multi_queue_linked_block_buffer_unit_test;
    import mqlb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXQ   = 1024;
    localparam int NBLK   = 4096;
    localparam int NSLOT  = 7;
    localparam int SETTLE = 32;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] pkt;
        logic [10:0] newq;
        logic [12:0] nfree;
    } outcome_t;

    typedef struct {
        logic [1:0]  kind;
        logic [10:0] qid;
        logic [31:0] pkt;
        bit          typed;
        logic [2:0]  status;
    } op_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [10:0] s_queue_id = '0;
    logic [31:0] s_packet_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_packet_out;
    logic [10:0] m_new_queue_id;
    logic [12:0] m_free_blocks;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;

    multi_queue_linked_block_buffer_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_queue_id(s_queue_id), .s_packet_in(s_packet_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_packet_out(m_packet_out), .m_new_queue_id(m_new_queue_id),
        .m_free_blocks(m_free_blocks),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow copy of the buffer state
    logic [10:0] limit_q;
    logic [11:0] head_of [MAXQ];
    logic [11:0] next_of [NBLK];
    logic [11:0] tail_of [NBLK];
    logic [31:0] slot_of [NBLK][NSLOT];
    logic [11:0] free_head;
    logic [12:0] free_cnt;
    logic [10:0] next_qnum;

    outcome_t pending[$];
    int       errors = 0;
    int       send_idle = 0;   // percent
    int       recv_idle = 0;
    bit       hold_off = 1'b0;
    int       qbound = 8;      // queues the random traffic addresses

    task automatic shadow_reset();
        limit_q = 11'd1024;
        for (int i = 0; i < MAXQ; i++) head_of[i] = '0;
        for (int i = 0; i < NBLK; i++) begin
            next_of[i] = (i + 1 < NBLK) ? 12'(i + 1) : '0;
            tail_of[i] = '0;
            for (int j = 0; j < NSLOT; j++) slot_of[i][j] = '0;
        end
        free_head = 12'd1;
        free_cnt = 13'(NBLK - 1);
        next_qnum = 11'd1;
    endtask

    function automatic logic [11:0] grab_block();
        logic [11:0] b;
        if (free_cnt <= 1 || free_head == 0) return '0;
        b = free_head;
        free_head = next_of[b];
        free_cnt--;
        next_of[b] = '0;
        tail_of[b] = '0;
        for (int j = 0; j < NSLOT; j++) slot_of[b][j] = '0;
        return b;
    endfunction

    function automatic logic [2:0] queue_append(int q, logic [31:0] p);
        logic [11:0] h, t, nb;
        if (p == 0) return ST_BAD_HANDLE;
        h = head_of[q - 1];
        if (h == 0) begin
            nb = grab_block();
            if (nb == 0) return ST_NO_BLOCKS;
            head_of[q - 1] = nb;
            slot_of[nb][0] = p;
            return ST_APPENDED;
        end
        t = (tail_of[h] == 0) ? h : tail_of[h];
        for (int i = 0; i < NSLOT; i++)
            if (slot_of[t][i] == 0) begin
                slot_of[t][i] = p;
                return ST_APPENDED;
            end
        nb = grab_block();
        if (nb == 0) return ST_NO_BLOCKS;
        slot_of[nb][0] = p;
        next_of[t] = nb;
        tail_of[h] = nb;
        return ST_APPENDED;
    endfunction

    function automatic logic [2:0] queue_remove(int q, output logic [31:0] p);
        logic [11:0] h, nx;
        p = '0;
        h = head_of[q - 1];
        if (h == 0) return ST_EMPTY;
        for (int i = 0; i < NSLOT; i++)
            if (slot_of[h][i] != 0) begin
                p = slot_of[h][i];
                slot_of[h][i] = '0;
                if (i + 1 >= NSLOT || slot_of[h][i + 1] == 0) begin
                    nx = next_of[h];
                    if (nx != 0) tail_of[nx] = tail_of[h];
                    head_of[q - 1] = nx;
                    next_of[h] = free_head;
                    free_head = h;
                    free_cnt++;
                end
                return ST_REMOVED;
            end
        return ST_CORRUPT;
    endfunction

    function automatic outcome_t buffer_predict(logic [1:0] k, logic [10:0] q, logic [31:0] p);
        outcome_t r;
        logic [31:0] got;
        bit ok;
        r = '0;
        ok = (q != 0) && (q <= limit_q) && (q <= MAXQ);
        if (k == KIND_CREATE) begin
            if (next_qnum <= limit_q && next_qnum <= MAXQ) r.newq = next_qnum;
            if (next_qnum <= MAXQ) next_qnum++;
            r.status = ST_CREATED;
        end else if (k == KIND_UNUSED || !ok) begin
            r.status = ST_BAD_QUEUE;
        end else if (k == KIND_APPEND) begin
            r.status = queue_append(q, p);
        end else begin
            r.status = queue_remove(q, got);
            r.pkt = got;
        end
        r.nfree = free_cnt;
        return r;
    endfunction

    // offer one word and hold it until taken; valid drops only while idling
    task automatic send_word(logic [1:0] k, logic [10:0] q, logic [31:0] p,
                             bit typed, logic [2:0] st);
        outcome_t r;
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= k;
        s_queue_id <= q;
        s_packet_in <= p;
        do @(posedge aclk); while (!s_ready);
        r = buffer_predict(k, q, p);
        if (typed && r.status != st) begin
            $display("%0t table status expected %0d actual %0d", $time, st, r.status);
            errors++;
        end
        pending.push_back(r);
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_valid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        while (n < SETTLE) begin
            @(posedge aclk);
            n++;
        end
    endtask

    task automatic write_limit(logic [10:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_q = v;
    endtask

    // result checking
    always @(posedge aclk) begin
        outcome_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending.size() == 0) begin
                $display("%0t unexpected word status %0d", $time, m_status);
                errors++;
            end else begin
                e = pending.pop_front();
                if (m_status !== e.status) begin
                    $display("%0t status expected %0d actual %0d", $time, e.status, m_status);
                    errors++;
                end
                if (m_packet_out !== e.pkt) begin
                    $display("%0t packet expected %h actual %h", $time, e.pkt, m_packet_out);
                    errors++;
                end
                if (m_new_queue_id !== e.newq) begin
                    $display("%0t new queue expected %0d actual %0d", $time, e.newq,
                             m_new_queue_id);
                    errors++;
                end
                if (m_free_blocks !== e.nfree) begin
                    $display("%0t free blocks expected %0d actual %0d", $time, e.nfree,
                             m_free_blocks);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end

    // long receiver hold-off so the input backs up
    task automatic stall_receiver();
        int n;
        n = 0;
        hold_off = 1'b1;
        while (n < 200) begin
            @(posedge aclk);
            n++;
        end
        hold_off = 1'b0;
    endtask

    task automatic random_word();
        int sel;
        logic [10:0] q;
        logic [31:0] p;
        sel = $urandom_range(99);
        q = 11'($urandom_range(1, qbound));
        p = $urandom;
        if (sel < 3) q = 11'($urandom_range(0, 2047));
        if (sel >= 3 && sel < 5) p = '0;
        if (sel < 50) send_word(KIND_APPEND, q, p, 0, '0);
        else if (sel < 95) send_word(KIND_REMOVE, q, p, 0, '0);
        else if (sel < 98) send_word(KIND_CREATE, q, p, 0, '0);
        else send_word(KIND_UNUSED, q, p, 0, '0);
    endtask

    op_row_t table_rows[$];

    initial begin
        shadow_reset();
        table_rows = '{
            '{KIND_REMOVE, 11'd1, 32'h0, 1, ST_EMPTY},
            '{KIND_APPEND, 11'd0, 32'h5, 1, ST_BAD_QUEUE},
            '{KIND_APPEND, 11'd1025, 32'h5, 1, ST_BAD_QUEUE},
            '{KIND_APPEND, 11'd2047, 32'h0, 1, ST_BAD_QUEUE},
            '{KIND_APPEND, 11'd1, 32'h0, 1, ST_BAD_HANDLE},
            '{KIND_UNUSED, 11'd1, 32'h1, 1, ST_BAD_QUEUE},
            '{KIND_CREATE, 11'd0, 32'h0, 1, ST_CREATED},
            '{KIND_APPEND, 11'd1, 32'hFFFFFFFF, 1, ST_APPENDED},
            '{KIND_APPEND, 11'd1024, 32'h1, 1, ST_APPENDED},
            '{KIND_APPEND, 11'd1, 32'h2, 0, '0},
            '{KIND_APPEND, 11'd1, 32'h3, 0, '0},
            '{KIND_APPEND, 11'd1, 32'h4, 0, '0},
            '{KIND_APPEND, 11'd1, 32'h5, 0, '0},
            '{KIND_APPEND, 11'd1, 32'h6, 0, '0},
            '{KIND_APPEND, 11'd1, 32'h7, 0, '0},
            '{KIND_APPEND, 11'd1, 32'hAAAA5555, 0, '0},
            '{KIND_REMOVE, 11'd1, 32'h0, 0, '0},
            '{KIND_REMOVE, 11'd1024, 32'h0, 0, '0},
            '{KIND_REMOVE, 11'd1024, 32'h0, 1, ST_EMPTY},
            '{KIND_REMOVE, 11'd0, 32'h0, 1, ST_BAD_QUEUE}
        };
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (table_rows[i])
            send_word(table_rows[i].kind, table_rows[i].qid, table_rows[i].pkt,
                      table_rows[i].typed, table_rows[i].status);

        // smallest limit, create exhaustion and queue bound
        write_limit(11'd1);
        send_word(KIND_CREATE, 11'd0, 32'h0, 0, '0);
        send_word(KIND_APPEND, 11'd2, 32'h9, 1, ST_BAD_QUEUE);
        send_word(KIND_REMOVE, 11'd1, 32'h0, 0, '0);
        write_limit(11'd2047);
        send_word(KIND_APPEND, 11'd1025, 32'h9, 1, ST_BAD_QUEUE);
        write_limit(11'd16);
        qbound = 16;

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 29 : 81) : 0;
            recv_idle = (ph == 2 || ph == 3) ? ((ph == 3) ? 29 : 81) : 0;
            if (ph == 0) fork stall_receiver(); join_none
            for (int i = 0; i < 100; i++) random_word();
            if (ph == 1) drain();
        end
        write_limit(11'd1024);
        qbound = 1024;
        send_idle = 0;
        recv_idle = 0;
        for (int i = 0; i < 50; i++) random_word();

        drain();
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
